// ===== rtl/dd_pkg.sv =====
// Shared types, constants and the month table for the date difference block.
// No dependencies; every other file imports this package.
package dd_pkg;

    // Field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int SPAN_W   = 23;
    localparam int DAYNUM_W = 24;
    localparam int CENT_W   = 8;
    localparam int LEAPS_W  = 14;
    localparam int TABLE_W  = 9;

    // Calendar constants
    localparam int DEFAULT_MAX_YEAR   = 9999;
    localparam int LAST_JULIAN_YEAR   = 1752;
    localparam int DAYS_PER_YEAR      = 365;
    localparam int CENTURY            = 100;
    localparam int QUAD_CENTURY       = 400;
    localparam int JULIAN_LEAPS       = LAST_JULIAN_YEAR / 4;
    localparam int GREG_LEAPS_JULIAN  = LAST_JULIAN_YEAR / 4 - LAST_JULIAN_YEAR / CENTURY
                                      + LAST_JULIAN_YEAR / QUAD_CENTURY;
    localparam int LEAP_OFFSET        = JULIAN_LEAPS - GREG_LEAPS_JULIAN;
    localparam int MONTH_FEB_IDX      = 1;
    localparam int MONTH_DEC          = 12;

    // Reciprocal of 100: exact floor for operands below 43690
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_W     = 13;
    localparam int PROD_W      = YEAR_W + RECIP_W;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified date
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [YEAR_W-1:0]  prev_year;
        logic [CENT_W-1:0]  year_cent;
        logic [CENT_W-1:0]  prev_cent;
        logic [MONTH_W-1:0] month_idx;
        logic [DAY_W-1:0]   day;
    } t_date;

    // One queued work word: both dates
    typedef struct packed {
        t_date date_a;
        t_date date_b;
    } t_pair;

    // Queue status toward the top level
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Days before the start of each month, non-leap year
    function automatic logic [TABLE_W-1:0] days_before(input logic [MONTH_W-1:0] idx);
        logic [TABLE_W-1:0] v;
        case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/dd_front.sv =====
// Front end: clamps the raw year and month fields and computes the century quotients.
// Depends on dd_pkg.
module dd_front #(
    parameter int MAX_YEAR = dd_pkg::DEFAULT_MAX_YEAR
) (
    input  logic [dd_pkg::YEAR_W-1:0]  i_first_year,
    input  logic [dd_pkg::MONTH_W-1:0] i_first_month,
    input  logic [dd_pkg::DAY_W-1:0]   i_first_day,
    input  logic [dd_pkg::YEAR_W-1:0]  i_second_year,
    input  logic [dd_pkg::MONTH_W-1:0] i_second_month,
    input  logic [dd_pkg::DAY_W-1:0]   i_second_day,
    output dd_pkg::t_pair              o_pair
);
    import dd_pkg::*;

    localparam int CMP_W = 17;

    // Clamp one date and divide year and year-1 by 100
    function automatic t_date classify(input logic [YEAR_W-1:0]  year,
                                       input logic [MONTH_W-1:0] month,
                                       input logic [DAY_W-1:0]   day);
        t_date              d;
        logic [YEAR_W-1:0]  y;
        logic [MONTH_W-1:0] m;
        logic [PROD_W-1:0]  prod_y;
        logic [PROD_W-1:0]  prod_n;
        y = (year == '0) ? YEAR_W'(1) : year;
        if (CMP_W'(y) > CMP_W'(MAX_YEAR)) begin
            y = YEAR_W'(MAX_YEAR);
        end
        m = month;
        if (m == '0) begin
            m = MONTH_W'(1);
        end
        if (m > MONTH_W'(MONTH_DEC)) begin
            m = MONTH_W'(MONTH_DEC);
        end
        d.year      = y;
        d.prev_year = y - YEAR_W'(1);
        prod_y      = PROD_W'(y) * PROD_W'(RECIP_100);
        prod_n      = PROD_W'(d.prev_year) * PROD_W'(RECIP_100);
        d.year_cent = prod_y[RECIP_SHIFT +: CENT_W];
        d.prev_cent = prod_n[RECIP_SHIFT +: CENT_W];
        d.month_idx = m - MONTH_W'(1);
        d.day       = day;
        return d;
    endfunction

    // Classify both dates
    always_comb begin
        o_pair.date_a = classify(i_first_year, i_first_month, i_first_day);
        o_pair.date_b = classify(i_second_year, i_second_month, i_second_day);
    end

endmodule

// ===== rtl/dd_queue.sv =====
// Short queue of classified date pairs between front and back end.
// Depends on dd_pkg.
module dd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dd_pkg::t_pair     i_data,
    input  logic              i_pop,
    output dd_pkg::t_pair     o_data,
    output dd_pkg::t_q_status o_status
);
    import dd_pkg::*;

    t_pair              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QPTR_W-1:0]  n_wr_ptr;
    logic [QPTR_W-1:0]  n_rd_ptr;
    logic [QCNT_W-1:0]  n_count;
    logic               w_push;
    logic               w_pop;

    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_data = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + QCNT_W'(1);
            2'b01:   n_count = r_count - QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/dd_back.sv =====
// Back end: turns both classified dates into day numbers and subtracts them.
// Three register stages; depends on dd_pkg.
module dd_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  dd_pkg::t_pair            i_pair,
    output logic                     o_valid,
    output logic [dd_pkg::SPAN_W-1:0] o_day_span
);
    import dd_pkg::*;

    localparam int CPROD_W = YEAR_W + 1;

    logic                r_v1;
    logic                r_v2;
    logic [DAYNUM_W-1:0] r_base_a;
    logic [DAYNUM_W-1:0] r_base_b;
    logic [LEAPS_W-1:0]  r_rest_a;
    logic [LEAPS_W-1:0]  r_rest_b;
    logic [DAYNUM_W-1:0] r_day_a;
    logic [DAYNUM_W-1:0] r_day_b;
    logic                r_valid;
    logic [SPAN_W-1:0]   r_span;

    // Leaps before the year, month offset, leap day and day of month
    function automatic logic [LEAPS_W-1:0] rest_days(input t_date d);
        logic [LEAPS_W-1:0] leaps;
        logic [CPROD_W-1:0] cent_back;
        logic               div4;
        logic               is_leap;
        if (d.prev_year <= YEAR_W'(LAST_JULIAN_YEAR)) begin
            leaps = LEAPS_W'(d.prev_year >> 2);
        end else begin
            leaps = LEAPS_W'(LEAP_OFFSET) + LEAPS_W'(d.prev_year >> 2)
                  + LEAPS_W'(d.prev_cent >> 2) - LEAPS_W'(d.prev_cent);
        end
        div4      = (d.year[1:0] == 2'b00);
        cent_back = CPROD_W'(d.year_cent) * CPROD_W'(CENTURY);
        if (d.year <= YEAR_W'(LAST_JULIAN_YEAR)) begin
            is_leap = div4;
        end else begin
            is_leap = div4 && ((cent_back != CPROD_W'(d.year)) || (d.year_cent[1:0] == 2'b00));
        end
        return leaps + LEAPS_W'(days_before(d.month_idx))
             + LEAPS_W'(is_leap && (d.month_idx > MONTH_W'(MONTH_FEB_IDX)))
             + LEAPS_W'(d.day);
    endfunction

    // Stage 1: whole-year days and the remainder per date
    always_ff @(posedge i_clk) begin
        r_base_a <= DAYNUM_W'(i_pair.date_a.prev_year) * DAYNUM_W'(DAYS_PER_YEAR);
        r_base_b <= DAYNUM_W'(i_pair.date_b.prev_year) * DAYNUM_W'(DAYS_PER_YEAR);
        r_rest_a <= rest_days(i_pair.date_a);
        r_rest_b <= rest_days(i_pair.date_b);
    end

    // Stage 2: day numbers
    always_ff @(posedge i_clk) begin
        r_day_a <= r_base_a + DAYNUM_W'(r_rest_a);
        r_day_b <= r_base_b + DAYNUM_W'(r_rest_b);
    end

    // Stage 3: difference, wrapped to the span width
    always_ff @(posedge i_clk) begin
        r_span <= SPAN_W'(r_day_b - r_day_a);
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_valid <= r_v2;
        end
    end

    assign o_valid    = r_valid;
    assign o_day_span = r_span;

endmodule

// ===== rtl/date_difference_days.sv =====
// Top level of the date difference block: front end, queue, back end.
// Depends on dd_pkg, dd_front, dd_queue and dd_back.
//
// Usage:
//   Drive both dates on the i_first_* and i_second_* ports and raise start.
//   The pair is taken at a rising edge where start is high and busy is low.
//   busy is high during reset and when the two-word queue is full; the back
//   end drains one word every cycle, so after reset busy stays low and a new
//   pair may be taken every cycle.
//   The signed day count (second minus first, 23-bit two's complement) shows
//   on o_day_span for exactly one cycle, marked by o_valid: the accepted pair
//   passes the queue register, then the whole-year product stage, the
//   day-number add stage and the subtract stage.
//   Throughput is one pair per cycle, as the back pipeline never stalls.
//   The receiver cannot stall the result; it must take it in that cycle.
//   Reset (synchronous, active low) empties the queue and drops any result
//   in flight. Years are clamped to 1..MAX_YEAR and months to 1..12.
module date_difference_days #(
    parameter int MAX_YEAR = dd_pkg::DEFAULT_MAX_YEAR
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [dd_pkg::YEAR_W-1:0]  i_first_year,
    input  logic [dd_pkg::MONTH_W-1:0] i_first_month,
    input  logic [dd_pkg::DAY_W-1:0]   i_first_day,
    input  logic [dd_pkg::YEAR_W-1:0]  i_second_year,
    input  logic [dd_pkg::MONTH_W-1:0] i_second_month,
    input  logic [dd_pkg::DAY_W-1:0]   i_second_day,
    output logic                       o_valid,
    output logic [dd_pkg::SPAN_W-1:0]  o_day_span
);
    import dd_pkg::*;

    t_pair     w_front_pair;
    t_pair     w_head_pair;
    t_q_status w_q_status;
    logic      w_accept;
    logic      w_pop;

    // Classify the incoming word
    dd_front #(
        .MAX_YEAR(MAX_YEAR)
    ) u_front (
        .i_first_year  (i_first_year),
        .i_first_month (i_first_month),
        .i_first_day   (i_first_day),
        .i_second_year (i_second_year),
        .i_second_month(i_second_month),
        .i_second_day  (i_second_day),
        .o_pair        (w_front_pair)
    );

    // Hold classified words until the back end takes them
    assign busy     = w_q_status.full || !i_rst_n;
    assign w_accept = start && !busy;
    assign w_pop    = !w_q_status.empty;

    dd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_front_pair),
        .i_pop   (w_pop),
        .o_data  (w_head_pair),
        .o_status(w_q_status)
    );

    // Compute the day span
    dd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_pop),
        .i_pair    (w_head_pair),
        .o_valid   (o_valid),
        .o_day_span(o_day_span)
    );

    // Every accepted word yields a result unless reset intervenes
    a_accept_to_result: assert property (@(posedge i_clk)
        ($past(w_accept, 4) && $past(i_rst_n, 3) && $past(i_rst_n, 2) && $past(i_rst_n, 1))
        |-> o_valid)
        else $error("accepted word produced no result");

    // No result without an earlier accepted word
    a_result_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, 4))
        else $error("result without an accepted word");

    // The back end drains every cycle, so the queue never fills after reset
    a_queue_never_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !w_q_status.full)
        else $error("queue filled although the back end never stalls");

endmodule

// ===== test/date_difference_days_test.sv =====
// Testbench for date_difference_days: drives date pairs through the start/busy
// handshake and checks each o_day_span word against a built-in day count.
// Depends on dd_pkg and the date_difference_days RTL.
module date_difference_days_test;

    timeunit 1ns;
    timeprecision 1ps;

    import dd_pkg::*;

    localparam int        BLOCK_MAX_YEAR = DEFAULT_MAX_YEAR;
    localparam int        RANDOM_PAIRS   = 1800;
    localparam int        QUIET_TAIL     = 300;
    localparam int        DRAIN_CYCLES   = 10;
    localparam int        CYCLE_LIMIT    = 200000;
    localparam int        MONTH_JAN      = 1;
    localparam int        MONTH_FEB      = 2;

    typedef struct {
        logic [YEAR_W-1:0]  first_year;
        logic [MONTH_W-1:0] first_month;
        logic [DAY_W-1:0]   first_day;
        logic [YEAR_W-1:0]  second_year;
        logic [MONTH_W-1:0] second_month;
        logic [DAY_W-1:0]   second_day;
        bit                 gaps_allowed;
    } t_date_pair;

    // Cumulative days before each month in a common year
    localparam int unsigned MONTH_START [12] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n;
    logic                 start          = 1'b0;
    logic                 busy;
    logic [YEAR_W-1:0]    i_first_year   = '0;
    logic [MONTH_W-1:0]   i_first_month  = '0;
    logic [DAY_W-1:0]     i_first_day    = '0;
    logic [YEAR_W-1:0]    i_second_year  = '0;
    logic [MONTH_W-1:0]   i_second_month = '0;
    logic [DAY_W-1:0]     i_second_day   = '0;
    logic                 o_valid;
    logic [SPAN_W-1:0]    o_day_span;

    t_date_pair           pairs_to_send[$];
    logic [SPAN_W-1:0]    spans_awaited[$];
    logic                 word_taken     = 1'b0;
    int                   idle_left      = 0;
    int                   mismatch_count = 0;
    int                   cycle_count    = 0;

    date_difference_days #(
        .MAX_YEAR(BLOCK_MAX_YEAR)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_first_year   (i_first_year),
        .i_first_month  (i_first_month),
        .i_first_day    (i_first_day),
        .i_second_year  (i_second_year),
        .i_second_month (i_second_month),
        .i_second_day   (i_second_day),
        .o_valid        (o_valid),
        .o_day_span     (o_day_span)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Julian rule through the cutover year, Gregorian after it
    function automatic bit leap_year(int unsigned y);
        if (y <= LAST_JULIAN_YEAR) begin
            return (y % 4) == 0;
        end
        return ((y % 4) == 0 && (y % CENTURY) != 0) || (y % QUAD_CENTURY) == 0;
    endfunction

    // Leap years among years 1 through n
    function automatic int unsigned leaps_upto(int unsigned n);
        int unsigned greg_n;
        int unsigned greg_cut;
        if (n <= LAST_JULIAN_YEAR) begin
            return n / 4;
        end
        greg_n   = n / 4 - n / CENTURY + n / QUAD_CENTURY;
        greg_cut = LAST_JULIAN_YEAR / 4 - LAST_JULIAN_YEAR / CENTURY
                 + LAST_JULIAN_YEAR / QUAD_CENTURY;
        return LAST_JULIAN_YEAR / 4 + greg_n - greg_cut;
    endfunction

    // Day ordinal of a date after clamping year and month, day taken as given
    function automatic longint day_ordinal(logic [YEAR_W-1:0] yr, logic [MONTH_W-1:0] mo,
                                           logic [DAY_W-1:0] dy);
        int unsigned y;
        int unsigned m;
        longint      n;
        y = 32'(yr);
        m = 32'(mo);
        if (y < 1) y = 1;
        if (y > BLOCK_MAX_YEAR) y = BLOCK_MAX_YEAR;
        if (m < MONTH_JAN) m = MONTH_JAN;
        if (m > MONTH_DEC) m = MONTH_DEC;
        n = longint'(DAYS_PER_YEAR) * (y - 1) + leaps_upto(y - 1);
        n += MONTH_START[m - 1];
        if (m > MONTH_FEB && leap_year(y)) n += 1;
        n += 64'(dy);
        return n;
    endfunction

    function automatic logic [SPAN_W-1:0] span_between(t_date_pair p);
        longint diff;
        diff = day_ordinal(p.second_year, p.second_month, p.second_day)
             - day_ordinal(p.first_year, p.first_month, p.first_day);
        return diff[SPAN_W-1:0];
    endfunction

    task automatic queue_pair(int y1, int m1, int d1, int y2, int m2, int d2, bit gaps);
        t_date_pair p;
        p.first_year   = YEAR_W'(y1);
        p.first_month  = MONTH_W'(m1);
        p.first_day    = DAY_W'(d1);
        p.second_year  = YEAR_W'(y2);
        p.second_month = MONTH_W'(m2);
        p.second_day   = DAY_W'(d2);
        p.gaps_allowed = gaps;
        pairs_to_send.push_back(p);
    endtask

    // Mostly legal years, weighted toward the calendar cutover and century years
    function automatic int pick_year();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return $urandom_range(1, BLOCK_MAX_YEAR);
        if (sel == 6) return $urandom_range(LAST_JULIAN_YEAR - 12, LAST_JULIAN_YEAR + 12);
        if (sel == 7) return CENTURY * $urandom_range(0, 99) + $urandom_range(0, 1);
        return $urandom_range(0, (1 << YEAR_W) - 1);
    endfunction

    function automatic int pick_month();
        if ($urandom_range(0, 6) == 0) return $urandom_range(0, (1 << MONTH_W) - 1);
        return $urandom_range(MONTH_JAN, MONTH_DEC);
    endfunction

    // Driver: present one word at a time, idle in random bursts between words
    always @(negedge i_clk) begin
        logic       next_start;
        t_date_pair p;
        next_start = start;
        if (!i_rst_n) next_start = 1'b0;
        if (start && word_taken) next_start = 1'b0;
        if (i_rst_n && !next_start && pairs_to_send.size() > 0) begin
            if (idle_left > 0) begin
                idle_left--;
            end else if (pairs_to_send[0].gaps_allowed && $urandom_range(0, 3) == 0) begin
                idle_left = $urandom_range(1, 18) - 1;
            end else begin
                p              = pairs_to_send.pop_front();
                i_first_year   <= p.first_year;
                i_first_month  <= p.first_month;
                i_first_day    <= p.first_day;
                i_second_year  <= p.second_year;
                i_second_month <= p.second_month;
                i_second_day   <= p.second_day;
                next_start     = 1'b1;
            end
        end
        start <= next_start;
    end

    // Monitor: check results in order, record the span of every accepted word
    always @(posedge i_clk) begin
        t_date_pair        taken;
        logic [SPAN_W-1:0] want;
        if (o_valid) begin
            if (spans_awaited.size() == 0) begin
                $display("%0t: unexpected day_span word, expected none, got %0d",
                         $time, $signed(o_day_span));
                mismatch_count++;
            end else begin
                want = spans_awaited.pop_front();
                if (o_day_span !== want) begin
                    $display("%0t: day_span mismatch, expected %0d, got %0d",
                             $time, $signed(want), $signed(o_day_span));
                    mismatch_count++;
                end
            end
        end
        if (start && !busy) begin
            taken.first_year   = i_first_year;
            taken.first_month  = i_first_month;
            taken.first_day    = i_first_day;
            taken.second_year  = i_second_year;
            taken.second_month = i_second_month;
            taken.second_day   = i_second_day;
            taken.gaps_allowed = 1'b0;
            spans_awaited.push_back(span_between(taken));
        end
        word_taken <= start && !busy;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words unsent, %0d results awaited",
                     $time, pairs_to_send.size(), spans_awaited.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;

        // Directed: field extremes, both leap rules, clamping, reversed order
        queue_pair(1, 1, 1, 1, 1, 1, 1'b1);
        queue_pair(1, 1, 1, BLOCK_MAX_YEAR, 12, 31, 1'b1);
        queue_pair(BLOCK_MAX_YEAR, 12, 31, 1, 1, 1, 1'b1);
        queue_pair(0, 0, 0, (1 << YEAR_W) - 1, 15, 31, 1'b1);
        queue_pair((1 << YEAR_W) - 1, 15, 31, 0, 0, 0, 1'b1);
        queue_pair(BLOCK_MAX_YEAR + 1, 13, 0, BLOCK_MAX_YEAR, 12, 0, 1'b1);
        queue_pair(0, 1, 5, 1, 1, 5, 1'b1);
        queue_pair(2000, 14, 1, 2000, 12, 1, 1'b1);
        queue_pair(1700, 2, 28, 1700, 3, 1, 1'b1);
        queue_pair(1800, 2, 28, 1800, 3, 1, 1'b1);
        queue_pair(1900, 2, 28, 1900, 3, 1, 1'b1);
        queue_pair(2000, 2, 28, 2000, 3, 1, 1'b1);
        queue_pair(1752, 2, 29, 1752, 3, 1, 1'b1);
        queue_pair(1752, 9, 2, 1752, 9, 14, 1'b1);
        queue_pair(1752, 12, 31, 1753, 1, 1, 1'b1);
        queue_pair(1600, 1, 1, 1900, 1, 1, 1'b1);
        queue_pair(1, 1, 1, 1753, 1, 1, 1'b1);
        queue_pair(1753, 1, 1, 2401, 1, 1, 1'b1);
        queue_pair(2023, 2, 31, 2023, 3, 3, 1'b1);
        queue_pair(2024, 2, 31, 2024, 3, 2, 1'b1);
        queue_pair(2024, 4, 0, 2024, 3, 31, 1'b1);
        queue_pair(1999, 12, 31, 2000, 1, 1, 1'b1);
        queue_pair(4, 3, 1, 4, 2, 29, 1'b1);

        // Random pairs, back-to-back stretches mixed in and a back-to-back tail
        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            queue_pair(pick_year(), pick_month(), $urandom_range(0, (1 << DAY_W) - 1),
                       pick_year(), pick_month(), $urandom_range(0, (1 << DAY_W) - 1),
                       (i < RANDOM_PAIRS - QUIET_TAIL) && ((i / 150) % 3 != 0));
        end

        // Hold reset, then release it at a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Drain the stimulus and the pipeline
        while (pairs_to_send.size() > 0 || start) @(posedge i_clk);
        while (spans_awaited.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && spans_awaited.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dd_pkg.sv
rtl/dd_front.sv
rtl/dd_queue.sv
rtl/dd_back.sv
rtl/date_difference_days.sv
test/date_difference_days_test.sv
